### src/tcgr_pkg.sv
// Shared types and constants for the text console glyph renderer.
// Depends on nothing; every other file of the block but tcgr_ram imports it.
package tcgr_pkg;

	// Glyph geometry
	localparam int unsigned GLYPH_ROWS      = 16;
	localparam int unsigned ROW_W           = $clog2(GLYPH_ROWS);
	localparam int unsigned GLYPH_COUNT_DEF = 256;
	localparam int unsigned CELL_W          = 8;
	localparam int unsigned LINE_H          = 16;

	// Input command codes
	localparam logic CMD_RENDER = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Special character codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0a;

	// Result kinds
	localparam logic [1:0] KIND_DRAW   = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_SCROLL = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_FG_COLOR      = 2'd0;
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_SCANLINE_PITCH = 2'd3;

	// Configuration reset values
	localparam logic [31:0] FG_COLOR_RST       = 32'hffff_ffff;
	localparam logic [11:0] SCREEN_WIDTH_RST   = 12'd1024;
	localparam logic [11:0] SCREEN_HEIGHT_RST  = 12'd768;
	localparam logic [12:0] SCANLINE_PITCH_RST = 13'd1024;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_code;
		logic [3:0] glyph_row;
		logic [7:0] glyph_bits;
	} request_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [23:0] pixel_offset;
		logic [7:0]  pixel_mask;
		logic [31:0] color;
		logic        last;
	} result_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_we;
		logic take;
		logic adv;
		logic chk;
		logic base;
		logic row;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_load;
		logic in_null;
		logic in_bksp;
		logic newline;
		logic row_last;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ADV  = 5'b00010,
		S_CHK  = 5'b00100,
		S_BASE = 5'b01000,
		S_ROWS = 5'b10000
	} state_t;

endpackage

### src/tcgr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tcgr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/tcgr_ctrl.sv
// Sequencer of the glyph renderer: walks advance, scroll check, base and row states.
// Depends on tcgr_pkg.
module tcgr_ctrl import tcgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	// Decode state into datapath commands and pick the next state
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (status.in_load) begin
						cmd.load_we = 1'b1;
					end else if (!status.in_null) begin
						cmd.take = 1'b1;
						state_d  = status.in_bksp ? S_BASE : S_ADV;
					end
				end
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				state_d = status.newline ? S_IDLE : S_BASE;
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d  = S_ROWS;
			end
			S_ROWS: begin
				cmd.row = 1'b1;
				if (status.row_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### src/tcgr_datapath.sv
// Datapath of the glyph renderer: registers, cursor, glyph store and result stage.
// Depends on tcgr_pkg and tcgr_ram.
module tcgr_datapath import tcgr_pkg::*; #(
	parameter int unsigned GLYPH_COUNT = GLYPH_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  request_t    request,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        strobe,
	output result_t     result
);

	localparam int unsigned CW    = $clog2(GLYPH_COUNT);
	localparam int unsigned DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [31:0]      fg_color_q;
	logic [11:0]      screen_width_q;
	logic [11:0]      screen_height_q;
	logic [12:0]      scanline_pitch_q;
	logic [11:0]      cursor_x_q;
	logic [11:0]      cursor_y_q;
	logic [7:0]       char_q;
	logic             in_range_q;
	logic [ROW_W-1:0] row_q;
	logic [23:0]      off_q;

	logic             valid_s1;
	logic [1:0]       kind_s1;
	logic [11:0]      x_s1;
	logic [11:0]      y_s1;
	logic [23:0]      off_s1;
	logic [7:0]       mask_s1;
	logic             use_ram_s1;
	logic [31:0]      color_s1;
	logic             last_s1;

	logic             in_range_in;
	logic             wrap;
	logic             need_scroll;
	logic             bksp_q;
	logic [7:0]       rdata;
	logic [24:0]      base_prod;

	// Status decode
	assign in_range_in     = ({1'b0, request.char_code} < 9'(GLYPH_COUNT));
	assign bksp_q          = (char_q == CH_BS);
	assign status.in_load  = (request.cmd == CMD_LOAD);
	assign status.in_null  = (request.char_code == CH_NUL);
	assign status.in_bksp  = (request.char_code == CH_BS);
	assign status.newline  = (char_q == CH_LF);
	assign status.row_last = (row_q == ROW_W'(GLYPH_ROWS - 1));

	assign wrap        = (({1'b0, cursor_x_q} + 13'(LINE_H)) > {1'b0, screen_width_q})
	                     || status.newline;
	assign need_scroll = (({1'b0, cursor_y_q} + 13'(LINE_H)) > {1'b0, screen_height_q});
	assign base_prod   = cursor_y_q * scanline_pitch_q;

	// Glyph store
	tcgr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (cmd.load_we && in_range_in),
		.waddr (AW'({request.char_code[CW-1:0], request.glyph_row})),
		.wdata (request.glyph_bits),
		.raddr (AW'({char_q[CW-1:0], row_q})),
		.rdata (rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q       <= FG_COLOR_RST;
			screen_width_q   <= SCREEN_WIDTH_RST;
			screen_height_q  <= SCREEN_HEIGHT_RST;
			scanline_pitch_q <= SCANLINE_PITCH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FG_COLOR:       fg_color_q       <= cfg_data;
				CFG_SCREEN_WIDTH:   screen_width_q   <= cfg_data[11:0];
				CFG_SCREEN_HEIGHT:  screen_height_q  <= cfg_data[11:0];
				CFG_SCANLINE_PITCH: scanline_pitch_q <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// Cursor: advance, scroll back, backspace after the last cleared row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (cmd.adv) begin
			if (wrap) begin
				cursor_x_q <= '0;
				cursor_y_q <= cursor_y_q + 12'(LINE_H);
			end else begin
				cursor_x_q <= cursor_x_q + 12'(CELL_W);
			end
		end else if (cmd.chk && need_scroll) begin
			cursor_y_q <= cursor_y_q - 12'(LINE_H);
		end else if (cmd.row && status.row_last && bksp_q) begin
			if (cursor_x_q < 12'(LINE_H)) begin
				cursor_x_q <= screen_width_q - 12'(CELL_W);
				cursor_y_q <= (cursor_y_q < 12'(LINE_H)) ? '0 : cursor_y_q - 12'(LINE_H);
			end else begin
				cursor_x_q <= cursor_x_q - 12'(CELL_W);
			end
		end
	end

	// Hold the character, row counter and running row offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.base) begin
			row_q <= '0;
		end else if (cmd.row) begin
			row_q <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q     <= request.char_code;
			in_range_q <= in_range_in;
		end
		if (cmd.base) begin
			off_q <= base_prod[23:0] + {12'd0, cursor_x_q};
		end else if (cmd.row) begin
			off_q <= off_q + {11'd0, scanline_pitch_q};
		end
	end

	// Result stage: one transfer per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (cmd.chk && need_scroll) || cmd.row;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			kind_s1    <= KIND_SCROLL;
			x_s1       <= '0;
			y_s1       <= '0;
			off_s1     <= '0;
			mask_s1    <= '0;
			use_ram_s1 <= 1'b0;
			color_s1   <= '0;
			last_s1    <= status.newline;
		end else if (cmd.row) begin
			kind_s1    <= bksp_q ? KIND_CLEAR : KIND_DRAW;
			x_s1       <= cursor_x_q;
			y_s1       <= cursor_y_q + 12'(row_q);
			off_s1     <= off_q;
			mask_s1    <= bksp_q ? 8'hff : 8'h00;
			use_ram_s1 <= !bksp_q && in_range_q;
			color_s1   <= bksp_q ? 32'd0 : fg_color_q;
			last_s1    <= status.row_last;
		end
	end

	assign strobe              = valid_s1;
	assign result.kind         = kind_s1;
	assign result.pixel_x      = x_s1;
	assign result.pixel_y      = y_s1;
	assign result.pixel_offset = off_s1;
	assign result.pixel_mask   = use_ram_s1 ? rdata : mask_s1;
	assign result.color        = color_s1;
	assign result.last         = last_s1;

endmodule

### src/text_console_glyph_renderer_unit.sv
// Text console glyph renderer: 8x16 character generator with a text cursor.
// A render is busy in the advance, check, base and row states (newline: advance and check only;
// backspace: base, rows); results are registered from the check and row states, one per cycle.
// Throughput: one glyph row per cycle, set by the single read port of the glyph RAM.
// Loads and byte zero take effect at the accepting edge and leave busy low.
// Reset: arst_n clears cursor, sequencer and strobe and restores the configuration defaults.
module text_console_glyph_renderer_unit import tcgr_pkg::*; #(
	parameter int unsigned GLYPH_COUNT = GLYPH_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  request_t    request,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        strobe,
	output result_t     result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Configuration writes are taken in any cycle
	assign cfg_ready = 1'b1;

	tcgr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	tcgr_datapath #(
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

### src/tcgr_checker.sv
// Port-level checks for the glyph renderer, bound to the top level.
// Depends on tcgr_pkg and text_console_glyph_renderer_unit.
module tcgr_checker import tcgr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input request_t request,
	input logic     strobe,
	input result_t  result
);

	// Results only while busy or right after it drops
	a_strobe_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (busy || $past(busy)))
		else $error("result transfer outside an item");

	// A glyph load never makes the block busy
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.cmd == CMD_LOAD) |=> !busy)
		else $error("load raised busy");

	// Scroll requests carry no coordinates, mask or colour
	a_scroll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.kind == KIND_SCROLL) |->
		(result.pixel_x == '0 && result.pixel_y == '0 && result.pixel_offset == '0
		 && result.pixel_mask == '0 && result.color == '0))
		else $error("scroll request with payload");

	// Cleared rows cover all pixels with zero
	a_clear_row: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.kind == KIND_CLEAR) |->
		(result.pixel_mask == 8'hff && result.color == '0))
		else $error("clear row malformed");

	// The last transfer of an item is followed by a gap
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("transfer right after last");

endmodule

bind text_console_glyph_renderer_unit tcgr_checker u_tcgr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.strobe  (strobe),
	.result  (result)
);
